[sv/slc_pkg.sv]
package slc_pkg;

   localparam int ID_W         = 64;
   localparam int HANDLE_W     = 32;
   localparam int NUM_SHARDS_W = 4;
   localparam int CAPACITY_W   = 5;
   localparam int CSR_W        = 5;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SHARDS     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARD_CAPACITY = 1'b1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic                op;
      logic [ID_W-1:0]     shard_id;
      logic [HANDLE_W-1:0] handle_in;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic [HANDLE_W-1:0] handle_out;
      logic                evicted;
      logic [HANDLE_W-1:0] evicted_handle;
   } rsp_type;

   typedef struct packed {
      logic commit;
      logic put;
      logic hit;
      logic evict;
   } cell_ctl_type;

   typedef struct packed {
      logic                found;
      logic [HANDLE_W-1:0] hit_handle;
      logic [HANDLE_W-1:0] ev_handle;
   } chain_type;

endpackage

[sv/sharded_lru_tag_cache.sv]
// sharded lru tag cache
// req channel (req_valid/req_ready/req_data) carries get or put transactions;
// rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one response per
// request, in order. csr_wr_en/csr_index/csr_wr_data write num_shards (index 0)
// and shard_capacity (index 1); write only while no transaction is in flight.
// timing: a request is taken in the idle cycle, the shard index is formed by a
// byte-serial modulo unit, then the row is read and updated in the update
// state; rsp_valid is registered from that update. a new request is taken only
// once the previous one has left the update state, so the modulo unit and the
// one-row read-modify-write across the chain of WAYS cells set the pace.
// a finished response sits in the output register; the next request is still
// accepted and worked on, but its update waits while rsp_valid is high and
// rsp_ready is low, so no response is lost or overwritten.
// reset: num_shards returns to 8, shard_capacity to 16 and every shard's fill
// count to zero; entry storage is not cleared and never read before written.
module sharded_lru_tag_cache
   import slc_pkg::*;
#(
   parameter int MAX_SHARDS  = 8,
   parameter int WAYS        = 16,
   parameter int HANDLE_BITS = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   localparam int N_W    = $clog2(MAX_SHARDS + 1);
   localparam int SW     = MAX_SHARDS > 1 ? $clog2(MAX_SHARDS) : 1;
   localparam int FILL_W = $clog2(WAYS + 1);
   localparam int HW     = HANDLE_BITS < HANDLE_W ? HANDLE_BITS : HANDLE_W;

   state_type               state_ff, state_in;
   req_type                 req_ff;
   logic [NUM_SHARDS_W-1:0] num_shards_ff;
   logic [CAPACITY_W-1:0]   capacity_ff;
   logic [FILL_W-1:0]       fill_ff [MAX_SHARDS];
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [N_W-1:0]    eff_shards;
   logic [FILL_W-1:0] eff_cap;
   logic              mod_done;
   logic [N_W-1:0]    residue;
   logic [SW-1:0]     shard;
   logic [FILL_W-1:0] fill_rd;
   logic              put;
   logic              ev;
   logic              commit;
   logic              accept;
   cell_ctl_type      ctl;
   logic [HW-1:0]     front_handle;

   chain_type       chain     [WAYS+1];
   logic [ID_W-1:0] rd_id     [WAYS];
   logic [HW-1:0]   rd_handle [WAYS];

   always_comb begin
      if (num_shards_ff == '0) begin
         eff_shards = N_W'(1);
      end else if (int'(num_shards_ff) > MAX_SHARDS) begin
         eff_shards = N_W'(MAX_SHARDS);
      end else begin
         eff_shards = N_W'(num_shards_ff);
      end
      if (capacity_ff == '0) begin
         eff_cap = FILL_W'(1);
      end else if (int'(capacity_ff) > WAYS) begin
         eff_cap = FILL_W'(WAYS);
      end else begin
         eff_cap = FILL_W'(capacity_ff);
      end
   end

   assign accept = req_valid && req_ready;

   slc_mod #(
      .N_W (N_W)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .id      (req_data.shard_id),
      .divisor (eff_shards),
      .done    (mod_done),
      .residue (residue)
   );

   assign shard   = residue[SW-1:0];
   assign fill_rd = fill_ff[shard];
   assign put     = req_ff.op == OP_PUT;
   assign ev      = put && (fill_rd != '0) && (fill_rd >= eff_cap);
   assign commit  = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   assign ctl.commit = commit;
   assign ctl.put    = put;
   assign ctl.hit    = chain[WAYS].found;
   assign ctl.evict  = ev;

   assign front_handle = put ? req_ff.handle_in[HW-1:0] : chain[WAYS].hit_handle[HW-1:0];

   assign chain[0] = '0;

   for (genvar k = 0; k < WAYS; k++) begin : g_cell
      logic [ID_W-1:0] nbr_id;
      logic [HW-1:0]   nbr_handle;
      if (k == 0) begin : g_head
         assign nbr_id     = req_ff.shard_id;
         assign nbr_handle = front_handle;
      end else begin : g_body
         assign nbr_id     = rd_id[k-1];
         assign nbr_handle = rd_handle[k-1];
      end
      slc_cell #(
         .SHARDS (MAX_SHARDS),
         .SLOT   (k),
         .FILL_W (FILL_W),
         .HW     (HW)
      ) u_cell (
         .clock      (clock),
         .shard      (shard),
         .key        (req_ff.shard_id),
         .fill       (fill_rd),
         .ctl        (ctl),
         .chain_in   (chain[k]),
         .nbr_id     (nbr_id),
         .nbr_handle (nbr_handle),
         .rd_id      (rd_id[k]),
         .rd_handle  (rd_handle[k]),
         .chain_out  (chain[k+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MOD;
         end
         ST_MOD: begin
            if (mod_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.hit            = !put && chain[WAYS].found;
         rsp_in.handle_out     = (!put && chain[WAYS].found) ? chain[WAYS].hit_handle : '0;
         rsp_in.evicted        = ev;
         rsp_in.evicted_handle = ev ? chain[WAYS].ev_handle : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         num_shards_ff <= NUM_SHARDS_W'(8);
         capacity_ff   <= CAPACITY_W'(16);
         for (int s = 0; s < MAX_SHARDS; s++) begin
            fill_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_NUM_SHARDS:     num_shards_ff <= csr_wr_data[NUM_SHARDS_W-1:0];
               CSR_SHARD_CAPACITY: capacity_ff   <= csr_wr_data[CAPACITY_W-1:0];
               default:            num_shards_ff <= num_shards_ff;
            endcase
         end
         if (commit && put) begin
            fill_ff[shard] <= ev ? fill_rd : fill_rd + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_rd <= FILL_W'(WAYS))
      else $error("shard fill count above ways");

   a_hit_or_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.hit && rsp_ff.evicted))
      else $error("response reports both hit and eviction");

   a_accept_starts_mod: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MOD))
      else $error("accepted request did not start the modulo unit");

   a_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("modulo result outside the modulo state");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised without an update");

endmodule

[sv/slc_mod.sv]
module slc_mod
   import slc_pkg::*;
#(
   parameter int N_W = 4
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [ID_W-1:0] id,
   input  logic [N_W-1:0]  divisor,
   output logic            done,
   output logic [N_W-1:0]  residue
);

   localparam int DIGIT_W = 8;
   localparam int DIGITS  = ID_W / DIGIT_W;
   localparam int CNT_W   = $clog2(DIGITS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ID_W-1:0]  sr_ff, sr_in;
   logic [N_W-1:0]   r_ff, r_in;
   logic [N_W-1:0]   r_step;

   // one byte per cycle, msb first, restoring reduction bit by bit
   always_comb begin : digit_step
      logic [N_W:0]   t;
      logic [N_W-1:0] r;
      r = r_ff;
      for (int b = 0; b < DIGIT_W; b++) begin
         t = {r, sr_ff[ID_W-1-b]};
         if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
         end
         r = t[N_W-1:0];
      end
      r_step = r;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sr_in   = sr_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sr_in   = id;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = r_step;
         sr_in  = sr_ff << DIGIT_W;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         r_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         r_ff    <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
   end

   assign done    = done_ff;
   assign residue = r_ff;

endmodule

[sv/slc_cell.sv]
module slc_cell
   import slc_pkg::*;
#(
   parameter int SHARDS = 8,
   parameter int SLOT   = 0,
   parameter int FILL_W = 5,
   parameter int HW     = 32
)
(
   input  logic                                clock,
   input  logic [(SHARDS > 1 ? $clog2(SHARDS) : 1)-1:0] shard,
   input  logic [ID_W-1:0]                     key,
   input  logic [FILL_W-1:0]                   fill,
   input  cell_ctl_type                        ctl,
   input  chain_type                           chain_in,
   input  logic [ID_W-1:0]                     nbr_id,
   input  logic [HW-1:0]                       nbr_handle,
   output logic [ID_W-1:0]                     rd_id,
   output logic [HW-1:0]                       rd_handle,
   output chain_type                           chain_out
);

   localparam logic [FILL_W-1:0] SLOT_AT   = FILL_W'(SLOT);
   localparam logic [FILL_W-1:0] SLOT_NEXT = FILL_W'(SLOT + 1);

   logic [ID_W-1:0] id_ff     [SHARDS];
   logic [HW-1:0]   handle_ff [SHARDS];
   logic [ID_W-1:0] rd_id_ff;
   logic [HW-1:0]   rd_handle_ff;

   logic                valid;
   logic                match;
   logic                wr;
   logic [HANDLE_W-1:0] handle_ext;

   assign valid      = SLOT_AT < fill;
   assign match      = valid && (rd_id_ff == key);
   assign handle_ext = HANDLE_W'(rd_handle_ff);

   assign chain_out.found      = chain_in.found | match;
   assign chain_out.hit_handle = chain_in.hit_handle |
                                 ((match && !chain_in.found) ? handle_ext : '0);
   assign chain_out.ev_handle  = chain_in.ev_handle |
                                 ((SLOT_NEXT == fill) ? handle_ext : '0);

   // put shifts everything kept, get shifts up to and including the hit
   always_comb begin
      if (ctl.put) begin
         wr = ctl.commit && (valid || (!ctl.evict && (SLOT_AT == fill)));
      end else begin
         wr = ctl.commit && ctl.hit && !chain_in.found;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         id_ff[shard]     <= nbr_id;
         handle_ff[shard] <= nbr_handle;
      end
      rd_id_ff     <= id_ff[shard];
      rd_handle_ff <= handle_ff[shard];
   end

   assign rd_id     = rd_id_ff;
   assign rd_handle = rd_handle_ff;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import slc_pkg::*;

   localparam int N_SHARDS    = 8;
   localparam int N_WAYS      = 16;
   localparam int DRAIN       = 12;
   localparam int CYCLE_LIMIT = 800000;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 280;

   localparam logic [ID_W-1:0]     ID_MAX = '1;
   localparam logic [HANDLE_W-1:0] H_MAX  = '1;
   localparam req_type             NO_REQ = '0;
   localparam rsp_type             NO_RSP = '0;

   typedef enum logic {
      ROW_ITEM,
      ROW_CFG
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic                  typed;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_W-1:0]      csr_val;
      req_type               req;
      rsp_type               rsp;
   } dir_row_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   req_type              req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CSR_W-1:0]     csr_wr_data = '0;

   logic [NUM_SHARDS_W-1:0] cfg_shards   = 4'd8;
   logic [CAPACITY_W-1:0]   cfg_capacity = 5'd16;
   logic [ID_W-1:0]         tag_id     [N_SHARDS*N_WAYS];
   logic [HANDLE_W-1:0]     tag_handle [N_SHARDS*N_WAYS];
   int                      fill_count [N_SHARDS];

   rsp_type         pending_rsp [$];
   logic [ID_W-1:0] id_pool [$];
   dir_row_type     dir_rows [26];
   rsp_type         want;

   int  errors    = 0;
   int  cycles    = 0;
   int  n_gets    = 0;
   int  n_puts    = 0;
   int  n_hits    = 0;
   int  n_evicts  = 0;
   int  n_writes  = 0;
   int  stall_left = 0;
   bit  quiet     = 1'b0;

   sharded_lru_tag_cache uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic rsp_type lru_apply(req_type r);
      rsp_type         res;
      int              shards;
      int              cap;
      int              fill;
      int              keep;
      int              base;
      int              pos;
      logic [ID_W-1:0] sh;
      res = '0;
      shards = (cfg_shards == 0) ? 1 : (cfg_shards > N_SHARDS) ? N_SHARDS : int'(cfg_shards);
      sh = r.shard_id % 64'(shards);
      base = int'(sh) * N_WAYS;
      fill = fill_count[sh];
      if (fill > N_WAYS) fill = N_WAYS;
      if (r.op == OP_PUT) begin
         cap = (cfg_capacity == 0) ? 1 : (cfg_capacity > N_WAYS) ? N_WAYS : int'(cfg_capacity);
         if (fill >= cap && fill > 0) begin
            res.evicted        = 1'b1;
            res.evicted_handle = tag_handle[base+fill-1];
            keep = fill - 1;
         end else begin
            keep = fill;
            fill = fill + 1;
         end
         for (int i = keep; i > 0; i--) begin
            tag_id[base+i]     = tag_id[base+i-1];
            tag_handle[base+i] = tag_handle[base+i-1];
         end
         tag_id[base]     = r.shard_id;
         tag_handle[base] = r.handle_in;
         fill_count[sh]   = fill;
      end else begin
         pos = fill;
         for (int i = fill - 1; i >= 0; i--)
            if (tag_id[base+i] == r.shard_id) pos = i;
         if (pos < fill) begin
            res.hit        = 1'b1;
            res.handle_out = tag_handle[base+pos];
            for (int i = pos; i > 0; i--) begin
               tag_id[base+i]     = tag_id[base+i-1];
               tag_handle[base+i] = tag_handle[base+i-1];
            end
            tag_id[base]     = r.shard_id;
            tag_handle[base] = res.handle_out;
         end
      end
      return res;
   endfunction

   task automatic send_item(input req_type r, input int gap, input bit typed,
                            input rsp_type typed_rsp);
      rsp_type res;
      if (gap > 0) repeat (gap) @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = lru_apply(r);
      pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : res);
      if (r.op == OP_PUT) n_puts++;
      else n_gets++;
      if (res.hit) n_hits++;
      if (res.evicted) n_evicts++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = val;
      if (idx == CSR_NUM_SHARDS) cfg_shards = val[NUM_SHARDS_W-1:0];
      else cfg_capacity = val[CAPACITY_W-1:0];
      n_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // response side backpressure
   always @(negedge clock) begin
      if (stall_left != 0) stall_left--;
      else if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      rsp_ready = (stall_left == 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response %h with no request pending", $time, rsp_data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $display("%0t: hit expected %b actual %b", $time, want.hit, rsp_data.hit);
               errors++;
            end
            if (rsp_data.handle_out !== want.handle_out) begin
               $display("%0t: handle_out expected %h actual %h",
                        $time, want.handle_out, rsp_data.handle_out);
               errors++;
            end
            if (rsp_data.evicted !== want.evicted) begin
               $display("%0t: evicted expected %b actual %b",
                        $time, want.evicted, rsp_data.evicted);
               errors++;
            end
            if (rsp_data.evicted_handle !== want.evicted_handle) begin
               $display("%0t: evicted_handle expected %h actual %h",
                        $time, want.evicted_handle, rsp_data.evicted_handle);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d responses outstanding", $time, pending_rsp.size());
         $display("sharded_lru_tag_cache: mismatch");
         $finish;
      end
   end

   initial begin : main
      req_type            r;
      logic [CSR_W-1:0]   shard_set [RAND_PHASES];
      logic [CSR_W-1:0]   cap_set   [RAND_PHASES];
      int                 pool_size;

      for (int i = 0; i < N_SHARDS*N_WAYS; i++) begin
         tag_id[i]     = '0;
         tag_handle[i] = '0;
      end
      for (int i = 0; i < N_SHARDS; i++) fill_count[i] = 0;

      dir_rows = '{
         {ROW_ITEM, 1'b1, CSR_NUM_SHARDS, 5'd0, {OP_GET, 64'd0, 32'd0},
          {1'b0, 32'd0, 1'b0, 32'd0}},
         {ROW_ITEM, 1'b1, CSR_NUM_SHARDS, 5'd0, {OP_GET, ID_MAX, 32'd0},
          {1'b0, 32'd0, 1'b0, 32'd0}},
         {ROW_ITEM, 1'b1, CSR_NUM_SHARDS, 5'd0, {OP_PUT, 64'd0, 32'd0},
          {1'b0, 32'd0, 1'b0, 32'd0}},
         {ROW_ITEM, 1'b1, CSR_NUM_SHARDS, 5'd0, {OP_PUT, ID_MAX, H_MAX},
          {1'b0, 32'd0, 1'b0, 32'd0}},
         {ROW_ITEM, 1'b1, CSR_NUM_SHARDS, 5'd0, {OP_GET, ID_MAX, 32'd0},
          {1'b1, H_MAX, 1'b0, 32'd0}},
         {ROW_ITEM, 1'b1, CSR_NUM_SHARDS, 5'd0, {OP_GET, 64'd0, 32'd0},
          {1'b1, 32'd0, 1'b0, 32'd0}},
         // duplicate id, newest wins
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_PUT, 64'd8, 32'h11}, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_PUT, 64'd0, 32'h22}, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_GET, 64'd0, 32'h0}, NO_RSP},
         // capacity below current fill
         {ROW_CFG, 1'b0, CSR_SHARD_CAPACITY, 5'd1, NO_REQ, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_PUT, 64'd16, 32'h33}, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_GET, 64'd8, 32'h0}, NO_RSP},
         {ROW_CFG, 1'b0, CSR_SHARD_CAPACITY, 5'd0, NO_REQ, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_PUT, 64'd24, 32'h44}, NO_RSP},
         {ROW_CFG, 1'b0, CSR_SHARD_CAPACITY, 5'd31, NO_REQ, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_PUT, 64'd32, 32'h55}, NO_RSP},
         // shard count zero, then saturated, then remapped
         {ROW_CFG, 1'b0, CSR_NUM_SHARDS, 5'd0, NO_REQ, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_GET, ID_MAX, 32'h0}, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_PUT, 64'd3, 32'hAAAA5555}, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_GET, 64'd3, 32'h0}, NO_RSP},
         {ROW_CFG, 1'b0, CSR_NUM_SHARDS, 5'd15, NO_REQ, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_GET, 64'd3, 32'h0}, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0,
          {OP_PUT, 64'h8000_0000_0000_0007, 32'h8000_0000}, NO_RSP},
         {ROW_CFG, 1'b0, CSR_NUM_SHARDS, 5'd5, NO_REQ, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0,
          {OP_GET, 64'h8000_0000_0000_0007, 32'h0}, NO_RSP},
         {ROW_ITEM, 1'b0, CSR_NUM_SHARDS, 5'd0, {OP_PUT, 64'd5, 32'h1234_5678}, NO_RSP}
      };

      shard_set = '{5'd8, 5'd1, 5'd2, 5'd7, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};
      cap_set   = '{5'd16, 5'd1, 5'd16, 5'd3, 5'($urandom_range(0, 31)),
                    5'($urandom_range(0, 31))};

      repeat (11) @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < $size(dir_rows); k++) begin
         if (dir_rows[k].kind == ROW_CFG)
            write_csr(dir_rows[k].csr_idx, dir_rows[k].csr_val);
         else
            send_item(dir_rows[k].req, pick_gap(), dir_rows[k].typed, dir_rows[k].rsp);
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         write_csr(CSR_NUM_SHARDS, shard_set[p]);
         write_csr(CSR_SHARD_CAPACITY, cap_set[p]);
         quiet = (p % 3 == 1);
         id_pool.delete();
         pool_size = $urandom_range(8, 48);
         for (int j = 0; j < pool_size; j++) begin
            if ($urandom_range(0, 1)) id_pool.insert(id_pool.size(), {$urandom, $urandom});
            else id_pool.insert(id_pool.size(), 64'($urandom_range(0, 63)));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r.op        = $urandom_range(0, 1) ? OP_PUT : OP_GET;
            r.handle_in = $urandom;
            if ($urandom_range(0, 9) == 0) r.shard_id = {$urandom, $urandom};
            else r.shard_id = id_pool[$urandom_range(0, pool_size - 1)];
            send_item(r, quiet ? 0 : pick_gap(), 1'b0, NO_RSP);
         end
      end

      quiet = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);

      $display("ran %0d transactions: %0d gets with %0d hits, %0d puts with %0d evictions",
               n_gets + n_puts, n_gets, n_hits, n_puts, n_evicts);
      $display("across %0d register writes, zero and saturated settings included", n_writes);
      if (errors == 0)
         $display("sharded_lru_tag_cache: match");
      else
         $display("sharded_lru_tag_cache: mismatch");
      $finish;
   end

endmodule
